### rtl/phd_pkg.sv
// Package with the shared types and constants of the presence debounce unit.
`default_nettype none

package phd_pkg;

	// Number of frames held in the voting window (1 to 127).
	localparam int unsigned WINDOW_LEN = 16;

	localparam int unsigned CONF_W  = 16;
	localparam int unsigned CNT_W   = 7;
	localparam int unsigned HOLD_W  = 20;
	localparam int unsigned TIME_W  = 32;
	localparam int unsigned CFG_W   = 20;
	localparam int unsigned CFG_IDX_W = 3;

	localparam logic [CONF_W-1:0] CONF_HIGH_RST = 16'd39322;
	localparam logic [CONF_W-1:0] CONF_LOW_RST  = 16'd26214;
	localparam logic [CNT_W-1:0]  TURN_ON_RST   = 7'd10;
	localparam logic [CNT_W-1:0]  STAY_ON_RST   = 7'd6;
	localparam logic [HOLD_W-1:0] MIN_HOLD_RST  = 20'd1000;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CONF_HIGH = 3'd0,
		CFG_CONF_LOW  = 3'd1,
		CFG_TURN_ON   = 3'd2,
		CFG_STAY_ON   = 3'd3,
		CFG_MIN_HOLD  = 3'd4
	} cfg_idx_t;

	typedef struct packed {
		logic              object_valid;
		logic              is_person;
		logic [CONF_W-1:0] confidence;
		logic              frame_end;
		logic [TIME_W-1:0] time_ms;
	} req_t;

	typedef struct packed {
		logic             present;
		logic             became_present;
		logic             became_absent;
		logic [CNT_W-1:0] window_hits;
	} res_t;

	// Window status for the frame being closed, as it will be after the shift.
	typedef struct packed {
		logic             full_next;
		logic [CNT_W-1:0] total_next;
	} win_stat_t;

endpackage

`default_nettype wire

### rtl/phd_cell.sv
// One window cell: holds the hit bit and the occupied bit of one frame.
`default_nettype none

module phd_cell (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic shift,
	input  wire logic hit_in,
	input  wire logic fill_in,
	output logic      hit_q,
	output logic      fill_q
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q  <= 1'b0;
			fill_q <= 1'b0;
		end else if (shift) begin
			hit_q  <= hit_in;
			fill_q <= fill_in;
		end
	end

endmodule

`default_nettype wire

### rtl/phd_window.sv
// Sliding window of frame hits built as a chain of cells, with a running hit count.
`default_nettype none

module phd_window (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         shift,
	input  wire logic         hit,
	output phd_pkg::win_stat_t stat
);

	import phd_pkg::*;

	logic [WINDOW_LEN-1:0] hit_q;
	logic [WINDOW_LEN-1:0] fill_q;
	logic [WINDOW_LEN-1:0] hit_src;
	logic [WINDOW_LEN-1:0] fill_src;
	logic [CNT_W-1:0]      total_q;
	logic                  drop;

	// Cell 0 takes the new frame; every other cell takes its neighbor's contents.
	assign hit_src[0]  = hit;
	assign fill_src[0] = 1'b1;

	for (genvar i = 0; i < WINDOW_LEN; i++) begin : g_cell
		if (i > 0) begin : g_link
			assign hit_src[i]  = hit_q[i-1];
			assign fill_src[i] = fill_q[i-1];
		end
		phd_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.shift  (shift),
			.hit_in (hit_src[i]),
			.fill_in(fill_src[i]),
			.hit_q  (hit_q[i]),
			.fill_q (fill_q[i])
		);
	end

	// The oldest frame leaves the window only when the window is already full.
	assign drop            = fill_q[WINDOW_LEN-1] & hit_q[WINDOW_LEN-1];
	assign stat.total_next = total_q - CNT_W'(drop) + CNT_W'(hit);
	assign stat.full_next  = fill_src[WINDOW_LEN-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
		end else if (shift) begin
			total_q <= stat.total_next;
		end
	end

endmodule

`default_nettype wire

### rtl/presence_hysteresis_debounce_unit.sv
// Top level of the presence debounce unit: thresholds, window vote and hold timer.
`default_nettype none

// Usage
// The request channel (req_valid, req_stall, req) carries one detected object or
// frame marker per request. A person whose confidence is strictly above the active
// threshold (conf_low while present, conf_high while absent) marks the frame as a hit.
// A request with frame_end set closes the frame: its hit bit shifts into a chain of
// WINDOW_LEN cells, and once the window is full the hit count is voted against the
// on or stay count, subject to the minimum hold time since the last change.
// Each frame-end request produces one result on (res_valid, res_stall, res) in the
// cycle after it is accepted; other requests produce nothing. One request is accepted
// per cycle. The result sits in an output register; while it is held by res_stall, a
// new request is accepted only in the cycle in which the held result is taken.
// Configuration is written through cfg_we, cfg_index and cfg_data while the unit is
// idle; writes to indexes past the last register are dropped.
// Reset clears the window cells, the running count, the frame hit flag, the presence
// state and the last change time, and restores the default register values.

module presence_hysteresis_debounce_unit (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       req_valid,
	output logic                            req_stall,
	input  wire phd_pkg::req_t              req,
	output logic                            res_valid,
	input  wire logic                       res_stall,
	output phd_pkg::res_t                   res,
	input  wire logic                       cfg_we,
	input  wire logic [phd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [phd_pkg::CFG_W-1:0]  cfg_data
);

	import phd_pkg::*;

	logic [CONF_W-1:0] conf_high_q;
	logic [CONF_W-1:0] conf_low_q;
	logic [CNT_W-1:0]  turn_on_q;
	logic [CNT_W-1:0]  stay_on_q;
	logic [HOLD_W-1:0] min_hold_q;

	logic              frame_hit_q;
	logic              present_q;
	logic [TIME_W-1:0] last_change_q;
	logic              res_valid_q;
	res_t              res_q;

	logic              accept;
	logic              close;
	logic [CONF_W-1:0] thr;
	logic              hit_now;
	logic [CNT_W-1:0]  need;
	logic              verdict;
	logic [TIME_W-1:0] elapsed;
	logic              change;
	win_stat_t         win;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			conf_high_q <= CONF_HIGH_RST;
			conf_low_q  <= CONF_LOW_RST;
			turn_on_q   <= TURN_ON_RST;
			stay_on_q   <= STAY_ON_RST;
			min_hold_q  <= MIN_HOLD_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_CONF_HIGH: conf_high_q <= cfg_data[CONF_W-1:0];
				CFG_CONF_LOW:  conf_low_q  <= cfg_data[CONF_W-1:0];
				CFG_TURN_ON:   turn_on_q   <= cfg_data[CNT_W-1:0];
				CFG_STAY_ON:   stay_on_q   <= cfg_data[CNT_W-1:0];
				CFG_MIN_HOLD:  min_hold_q  <= cfg_data[HOLD_W-1:0];
				default: ;
			endcase
		end
	end

	// A new request may enter whenever the output register is empty or being drained.
	assign req_stall = res_valid_q & res_stall;
	assign accept    = req_valid & ~req_stall;
	assign close     = accept & req.frame_end;

	// The object is judged against the threshold of the current state, and counts
	// toward the frame even when it rides on the frame-end request.
	assign thr     = present_q ? conf_low_q : conf_high_q;
	assign hit_now = frame_hit_q |
	                 (req.object_valid & req.is_person & (req.confidence > thr));

	phd_window u_window (
		.clk   (clk),
		.arst_n(arst_n),
		.shift (close),
		.hit   (hit_now),
		.stat  (win)
	);

	// Vote with hysteresis on the count; a full window and the hold timer gate any change.
	// The elapsed time is a wrapping 32-bit difference.
	assign need    = present_q ? stay_on_q : turn_on_q;
	assign verdict = win.total_next >= need;
	assign elapsed = req.time_ms - last_change_q;
	assign change  = win.full_next & (verdict != present_q) &
	                 (elapsed >= TIME_W'(min_hold_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_hit_q   <= 1'b0;
			present_q     <= 1'b0;
			last_change_q <= '0;
		end else if (accept) begin
			frame_hit_q <= hit_now & ~req.frame_end;
			if (close && change) begin
				present_q     <= verdict;
				last_change_q <= req.time_ms;
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (close) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (close) begin
			res_q.present        <= change ? verdict : present_q;
			res_q.became_present <= change & verdict;
			res_q.became_absent  <= change & ~verdict;
			res_q.window_hits    <= win.total_next;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

`default_nettype wire

### rtl/phd_checker.sv
// Port-level checks for the presence debounce unit and the bind that attaches them.
`default_nettype none

module phd_checker (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          req_valid,
	input  wire logic                          req_stall,
	input  wire phd_pkg::req_t                 req,
	input  wire logic                          res_valid,
	input  wire logic                          res_stall,
	input  wire phd_pkg::res_t                 res
);

	import phd_pkg::*;

	// Both change pulses never appear in the same result.
	a_one_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !(res.became_present && res.became_absent))
		else $error("both change pulses set");

	// A pulse agrees with the state it reports.
	a_pulse_state: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (!res.became_present || res.present) &&
		              (!res.became_absent || !res.present))
		else $error("change pulse disagrees with present");

	// The window count never exceeds the window length.
	a_hits_bound: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res.window_hits <= CNT_W'(WINDOW_LEN))
		else $error("window hit count out of range");

	// A held result stays in place.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res))
		else $error("stalled result changed");

	// A stalled request stays in place until it is taken.
	a_req_hold: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_stall |=> req_valid && $stable(req))
		else $error("stalled request changed");

endmodule

bind presence_hysteresis_debounce_unit phd_checker u_phd_checker (.*);

`default_nettype wire
